@@ sv/ax25ap_pkg.sv @@
`default_nettype none
package ax25ap_pkg;

	localparam int ADDRESS_BYTES = 7;
	localparam int MAX_DIGIS_DEF = 8;

	// Bit positions inside an SSID byte
	localparam int BIT_C = 7;
	localparam int BIT_H = 7;
	localparam int BIT_E = 0;

	typedef enum logic [2:0] {
		REG_DEST    = 3'd0,
		REG_SOURCE  = 3'd1,
		REG_DIGI    = 3'd2,
		REG_PAYLOAD = 3'd3,
		REG_DISCARD = 3'd4
	} region_t;

	typedef enum logic [2:0] {
		PH_DEST    = 3'd0,
		PH_SOURCE  = 3'd1,
		PH_DIGI    = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_DISCARD = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		CR_UNKNOWN  = 2'd0,
		CR_COMMAND  = 2'd1,
		CR_RESPONSE = 2'd2
	} cr_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_TRUNC = 2'd1,
		ERR_DIGIS = 2'd2
	} err_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_last;
	} item_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic [2:0] region;
		logic [3:0] address_index;
		logic [2:0] byte_position;
		logic       header_done;
		logic       error_flag;
		logic [1:0] error_kind;
		logic [1:0] cmd_resp;
		logic [3:0] digi_count;
		logic [3:0] repeated_count;
		logic       frame_end;
	} result_t;

	// Classified byte handed from the parser front to the back end
	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_last;
		region_t    region;
		logic [3:0] address_index;
		logic [2:0] byte_position;
		logic       ssid;
		logic       header_done;
		logic       error_flag;
		err_t       error_kind;
	} cls_t;

endpackage
`default_nettype wire

@@ sv/ax25ap_front.sv @@
`default_nettype none
module ax25ap_front
	import ax25ap_pkg::*;
#(
	parameter int MAX_DIGIS = MAX_DIGIS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  take,
	input  wire item_t item,
	output cls_t       cls
);

	localparam logic [2:0] SSID_POS = 3'(ADDRESS_BYTES - 1);
	localparam logic [3:0] DIGI_LIMIT = 4'(MAX_DIGIS + 1);

	phase_t     phase_q, phase_d;
	logic [2:0] pos_q, pos_d;
	logic [3:0] addr_q, addr_d;
	logic       ssid;
	logic       e_bit;

	assign ssid  = (pos_q >= SSID_POS);
	assign e_bit = item.data_byte[BIT_E];

	// Next parse state
	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		addr_d  = addr_q;
		case (phase_q)
			PH_DEST: begin
				if (ssid) begin
					phase_d = PH_SOURCE;
					addr_d  = 4'd1;
					pos_d   = 3'd0;
				end else begin
					pos_d = pos_q + 3'd1;
				end
			end
			PH_SOURCE: begin
				if (ssid) begin
					pos_d = 3'd0;
					if (e_bit) begin
						phase_d = PH_PAYLOAD;
					end else begin
						phase_d = PH_DIGI;
						addr_d  = 4'd2;
					end
				end else begin
					pos_d = pos_q + 3'd1;
				end
			end
			PH_DIGI: begin
				if (ssid) begin
					pos_d = 3'd0;
					if (e_bit) begin
						phase_d = PH_PAYLOAD;
					end else if (addr_q >= DIGI_LIMIT) begin
						phase_d = PH_DISCARD;
					end else begin
						addr_d = addr_q + 4'd1;
					end
				end else begin
					pos_d = pos_q + 3'd1;
				end
			end
			PH_PAYLOAD: begin
			end
			default: begin
			end
		endcase
	end

	// Classify the current beat
	always_comb begin
		cls.data_byte     = item.data_byte;
		cls.frame_last    = item.frame_last;
		cls.ssid          = ssid;
		cls.address_index = addr_q;
		cls.byte_position = pos_q;
		cls.header_done   = 1'b0;
		cls.error_flag    = 1'b0;
		cls.error_kind    = ERR_NONE;
		case (phase_q)
			PH_DEST: begin
				cls.region = REG_DEST;
			end
			PH_SOURCE: begin
				cls.region = REG_SOURCE;
				cls.header_done = ssid && e_bit;
			end
			PH_DIGI: begin
				cls.region = REG_DIGI;
				if (ssid && e_bit) begin
					cls.header_done = 1'b1;
				end else if (ssid && addr_q >= DIGI_LIMIT) begin
					cls.error_flag = 1'b1;
					cls.error_kind = ERR_DIGIS;
				end
			end
			PH_PAYLOAD: begin
				cls.region        = REG_PAYLOAD;
				cls.address_index = 4'd0;
				cls.byte_position = 3'd0;
			end
			default: begin
				cls.region        = REG_DISCARD;
				cls.address_index = 4'd0;
				cls.byte_position = 3'd0;
			end
		endcase
		// Flag a frame that ends inside the address field
		if (item.frame_last && cls.region < REG_PAYLOAD && !cls.header_done
				&& !cls.error_flag) begin
			cls.error_flag = 1'b1;
			cls.error_kind = ERR_TRUNC;
		end
	end

	// Advance on each accepted beat; restart at the frame boundary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DEST;
			pos_q   <= 3'd0;
			addr_q  <= 4'd0;
		end else if (take) begin
			if (item.frame_last) begin
				phase_q <= PH_DEST;
				pos_q   <= 3'd0;
				addr_q  <= 4'd0;
			end else begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				addr_q  <= addr_d;
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/ax25ap_queue.sv @@
`default_nettype none
module ax25ap_queue
	import ax25ap_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cls_t push_data,
	output logic      full,
	input  wire logic pop,
	output logic      not_empty,
	output cls_t      pop_data
);

	cls_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign pop_data  = mem_q[rd_q];

	// Store pushed beats
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/ax25ap_back.sv @@
`default_nettype none
module ax25ap_back
	import ax25ap_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	input  wire cls_t q_data,
	output logic      q_pop,
	output logic      result_valid,
	input  wire logic result_stall,
	output result_t   result
);

	logic       dest_c_q, dest_c_d;
	cr_t        cr_q, cr_d;
	logic [3:0] digi_q, digi_d;
	logic [3:0] rep_q, rep_d;
	logic       src_c;

	assign q_pop = q_valid && (!result_valid || !result_stall);
	assign src_c = q_data.data_byte[BIT_C];

	// Update frame statistics from SSID bytes
	always_comb begin
		dest_c_d = dest_c_q;
		cr_d     = cr_q;
		digi_d   = digi_q;
		rep_d    = rep_q;
		if (q_data.ssid) begin
			case (q_data.region)
				REG_DEST: begin
					dest_c_d = q_data.data_byte[BIT_C];
				end
				REG_SOURCE: begin
					if (src_c == dest_c_q) begin
						cr_d = CR_UNKNOWN;
					end else if (src_c) begin
						cr_d = CR_RESPONSE;
					end else begin
						cr_d = CR_COMMAND;
					end
				end
				REG_DIGI: begin
					digi_d = digi_q + 4'd1;
					if (q_data.data_byte[BIT_H]) begin
						rep_d = rep_q + 4'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Hold statistics, clearing at each frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_c_q <= 1'b0;
			cr_q     <= CR_UNKNOWN;
			digi_q   <= 4'd0;
			rep_q    <= 4'd0;
		end else if (q_pop) begin
			if (q_data.frame_last) begin
				dest_c_q <= 1'b0;
				cr_q     <= CR_UNKNOWN;
				digi_q   <= 4'd0;
				rep_q    <= 4'd0;
			end else begin
				dest_c_q <= dest_c_d;
				cr_q     <= cr_d;
				digi_q   <= digi_d;
				rep_q    <= rep_d;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (q_pop) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			result.byte_out       <= q_data.data_byte;
			result.region         <= q_data.region;
			result.address_index  <= q_data.address_index;
			result.byte_position  <= q_data.byte_position;
			result.header_done    <= q_data.header_done;
			result.error_flag     <= q_data.error_flag;
			result.error_kind     <= q_data.error_kind;
			result.cmd_resp       <= cr_d;
			result.digi_count     <= digi_d;
			result.repeated_count <= rep_d;
			result.frame_end      <= q_data.frame_last;
		end
	end

endmodule
`default_nettype wire

@@ sv/ax25_address_parser_top.sv @@
`default_nettype none
// AX.25 address field parser. Takes one frame byte per beat (frame_last on
// the final byte) and returns one tagged result per byte: region, address
// index, byte position, header-done and error marks, command/response and
// digipeater counts. It sustains one byte per clock while neither side
// stalls; a result passes through the queue and the output register.
// The rate is set by the update of the address parse state in the front
// stage; a two-entry queue and the output register let input and output
// stall independently, so item_stall rises only when both are full.
module ax25_address_parser_top
	import ax25ap_pkg::*;
#(
	parameter int MAX_DIGIS = MAX_DIGIS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_stall,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	cls_t cls;
	cls_t q_data;
	logic take;
	logic q_full;
	logic q_valid;
	logic q_pop;

	assign item_stall = q_full;
	assign take       = item_valid && !q_full;

	ax25ap_front #(
		.MAX_DIGIS(MAX_DIGIS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item),
		.cls    (cls)
	);

	ax25ap_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_data (cls),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_data)
	);

	ax25ap_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

@@ dv/tb_ax25_address_parser_top.sv @@
`timescale 1ns / 1ps

module tb_ax25_address_parser_top;
	import ax25ap_pkg::*;

	localparam int MAX_DIGI     = MAX_DIGIS_DEF;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PRINT_LIMIT  = 40;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// Idle rates in percent, per cycle
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// Long receiver hold-off, requested by bumping hold_seq
	int hold_seq  = 0;
	int hold_seen = 0;
	int hold_left = 0;

	int bytes_sent     = 0;
	int mismatch_count = 0;
	int quiet_cycles   = 0;

	// Address parse state mirrored by the predictor
	phase_t     ps_phase;
	logic [2:0] ps_pos;
	logic [3:0] ps_addr;
	logic       ps_dest_c;
	cr_t        ps_cr;
	logic [3:0] ps_digis;
	logic [3:0] ps_reps;

	result_t parse_due[$];

	ax25_address_parser_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void clear_parse_state();
		ps_phase  = PH_DEST;
		ps_pos    = '0;
		ps_addr   = '0;
		ps_dest_c = 1'b0;
		ps_cr     = CR_UNKNOWN;
		ps_digis  = '0;
		ps_reps   = '0;
	endfunction

	// Tag one frame byte and advance the parse state
	function automatic result_t classify_byte(item_t it);
		result_t    r;
		logic       ssid_byte;
		logic [7:0] b;
		b = it.data_byte;
		r = '0;
		r.byte_out      = b;
		r.region        = ps_phase;
		r.address_index = ps_addr;
		r.byte_position = ps_pos;
		r.error_kind    = ERR_NONE;
		r.frame_end     = it.frame_last;
		ssid_byte = (int'(ps_pos) >= ADDRESS_BYTES - 1);
		case (ps_phase)
			PH_DEST: begin
				// E bit of the destination is ignored
				if (ssid_byte) begin
					ps_dest_c = b[BIT_C];
					ps_phase  = PH_SOURCE;
					ps_addr   = 4'd1;
					ps_pos    = '0;
				end else begin
					ps_pos = ps_pos + 3'd1;
				end
			end
			PH_SOURCE: begin
				if (ssid_byte) begin
					if (b[BIT_C] == ps_dest_c)
						ps_cr = CR_UNKNOWN;
					else if (b[BIT_C])
						ps_cr = CR_RESPONSE;
					else
						ps_cr = CR_COMMAND;
					ps_pos = '0;
					if (b[BIT_E]) begin
						r.header_done = 1'b1;
						ps_phase      = PH_PAYLOAD;
					end else begin
						ps_phase = PH_DIGI;
						ps_addr  = 4'd2;
					end
				end else begin
					ps_pos = ps_pos + 3'd1;
				end
			end
			PH_DIGI: begin
				if (ssid_byte) begin
					ps_digis = ps_digis + 4'd1;
					if (b[BIT_H])
						ps_reps = ps_reps + 4'd1;
					ps_pos = '0;
					if (b[BIT_E]) begin
						r.header_done = 1'b1;
						ps_phase      = PH_PAYLOAD;
					end else if (int'(ps_digis) >= MAX_DIGI) begin
						r.error_flag = 1'b1;
						r.error_kind = ERR_DIGIS;
						ps_phase     = PH_DISCARD;
					end else begin
						ps_addr = ps_addr + 4'd1;
					end
				end else begin
					ps_pos = ps_pos + 3'd1;
				end
			end
			PH_PAYLOAD: begin
				r.region        = REG_PAYLOAD;
				r.address_index = '0;
				r.byte_position = '0;
			end
			default: begin
				r.region        = REG_DISCARD;
				r.address_index = '0;
				r.byte_position = '0;
			end
		endcase
		// Frame ended inside the address field
		if (it.frame_last && r.region < REG_PAYLOAD && !r.header_done && !r.error_flag) begin
			r.error_flag = 1'b1;
			r.error_kind = ERR_TRUNC;
		end
		r.cmd_resp       = ps_cr;
		r.digi_count     = ps_digis;
		r.repeated_count = ps_reps;
		if (it.frame_last)
			clear_parse_state();
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		if (mismatch_count < PRINT_LIMIT)
			$display("%0t ns: check failed on %s: expected 0x%0h, got 0x%0h",
				$realtime, what, want, got);
		mismatch_count++;
	endtask

	task automatic compare_result(input result_t got, input result_t want);
		if (got.byte_out !== want.byte_out)
			report_mismatch("byte_out", want.byte_out, got.byte_out);
		if (got.region !== want.region)
			report_mismatch("region", want.region, got.region);
		if (got.address_index !== want.address_index)
			report_mismatch("address_index", want.address_index, got.address_index);
		if (got.byte_position !== want.byte_position)
			report_mismatch("byte_position", want.byte_position, got.byte_position);
		if (got.header_done !== want.header_done)
			report_mismatch("header_done", want.header_done, got.header_done);
		if (got.error_flag !== want.error_flag)
			report_mismatch("error_flag", want.error_flag, got.error_flag);
		if (got.error_kind !== want.error_kind)
			report_mismatch("error_kind", want.error_kind, got.error_kind);
		if (got.cmd_resp !== want.cmd_resp)
			report_mismatch("cmd_resp", want.cmd_resp, got.cmd_resp);
		if (got.digi_count !== want.digi_count)
			report_mismatch("digi_count", want.digi_count, got.digi_count);
		if (got.repeated_count !== want.repeated_count)
			report_mismatch("repeated_count", want.repeated_count, got.repeated_count);
		if (got.frame_end !== want.frame_end)
			report_mismatch("frame_end", want.frame_end, got.frame_end);
	endtask

	// Check each result beat, then predict the accepted input beat
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (parse_due.size() == 0) begin
					report_mismatch("result with none expected", 0, result.byte_out);
				end else begin
					want = parse_due.pop_front();
					compare_result(result, want);
				end
			end
			if (item_valid && !item_stall)
				parse_due.push_back(classify_byte(item));
		end
	end

	// Drive result_stall: long hold-off on request, random stalls otherwise
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no beat accepted for %0d cycles, %0d results outstanding",
				STALL_LIMIT, parse_due.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// Offer one byte, with random idle cycles ahead of it, and hold until taken
	task automatic send_byte(input logic [7:0] b, input logic last);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		item_valid      <= 1'b1;
		item.data_byte  <= b;
		item.frame_last <= last;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [7:0] bytes[$]);
		foreach (bytes[i])
			send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	// Append one address: six random bytes and the given SSID byte
	function automatic void push_address(ref logic [7:0] bytes[$], input logic [7:0] ssid);
		for (int i = 0; i < ADDRESS_BYTES - 1; i++)
			bytes.push_back(8'($urandom));
		bytes.push_back(ssid);
	endfunction

	// Build a frame: mostly well formed, some cut short, some noise
	task automatic send_random_frame();
		logic [7:0] bytes[$];
		logic [7:0] ssid;
		int         kind;
		int         ndigi;
		int         cut;
		int         pick;
		kind = $urandom_range(99);
		if (kind >= 90) begin
			repeat ($urandom_range(1, 24))
				bytes.push_back(8'($urandom));
		end else begin
			pick = $urandom_range(9);
			if (pick < 6)
				ndigi = $urandom_range(3);
			else if (pick < 8)
				ndigi = $urandom_range(MAX_DIGI);
			else
				ndigi = MAX_DIGI + $urandom_range(1);
			push_address(bytes, 8'($urandom));
			ssid = 8'($urandom);
			ssid[BIT_E] = (ndigi == 0);
			push_address(bytes, ssid);
			for (int d = 0; d < ndigi; d++) begin
				ssid = 8'($urandom);
				ssid[BIT_E] = (d == ndigi - 1);
				push_address(bytes, ssid);
			end
			repeat ($urandom_range(0, 6))
				bytes.push_back(8'($urandom));
			// Cut the frame short somewhere
			if (kind >= 75) begin
				cut = $urandom_range(1, bytes.size());
				while (bytes.size() > cut)
					void'(bytes.pop_back());
			end
		end
		send_frame(bytes);
	endtask

	task automatic run_random_frames(input int count);
		int target;
		target = bytes_sent + count;
		while (bytes_sent < target)
			send_random_frame();
	endtask

	// Extreme bytes, ignored destination E bit, command frame, truncation
	task automatic test_directed_frames();
		logic [7:0] bytes[$];
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// dest SSID with C and E set; source SSID C clear, E set; one payload byte
		bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h81,
			8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h7F, 8'hFF};
		send_frame(bytes);
		// one-byte frame, truncated on the first destination byte
		bytes = '{8'hFF};
		send_frame(bytes);
		// frame that ends two bytes into the source address
		bytes = '{8'hA5, 8'h5A, 8'h01, 8'hFE, 8'h80, 8'h7F, 8'h00, 8'h55, 8'hAA};
		send_frame(bytes);
	endtask

	task automatic test_random_sender_gaps();
		send_idle_pct = 10;
		recv_idle_pct = 71;
		run_random_frames(480);
	endtask

	task automatic test_random_receiver_gaps();
		send_idle_pct = 71;
		recv_idle_pct = 10;
		run_random_frames(480);
	endtask

	task automatic test_random_streaming();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random_frames(400);
	endtask

	// Hold the output off for a long stretch while bytes keep coming
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_seq <= hold_seq + 1;
		run_random_frames(60);
	endtask

	initial begin
		clear_parse_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_random_sender_gaps();
		test_random_receiver_gaps();
		test_random_streaming();
		test_output_backpressure();

		// Drain: stop sending and wait for every expected result
		item_valid <= 1'b0;
		while (parse_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
